### rtl/core/aabb_pkg.sv
// Package for the box table collision query block.
// Holds request/result structs, command codes, state enum and sizing constants.
package aabb_pkg;

  localparam int BOXES_DEF      = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int IDX_BITS       = 4;
  localparam int T_BITS         = 17;
  localparam int FRAC_BITS      = 16;
  localparam int MAX_HITS       = 64;
  localparam int HIT_AW         = 6;
  localparam int TAG_BITS       = 16;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_POINT  = 3'd2,
    CMD_RECT   = 3'd3,
    CMD_SEG    = 3'd4
  } cmd_t;

  localparam logic [1:0] FACE_YMIN = 2'd0;
  localparam logic [1:0] FACE_XMIN = 2'd1;
  localparam logic [1:0] FACE_YMAX = 2'd2;
  localparam logic [1:0] FACE_XMAX = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] coord_a_x;
    logic signed [15:0] coord_a_y;
    logic signed [15:0] coord_b_x;
    logic signed [15:0] coord_b_y;
    logic [15:0]        name_tag;
    logic [15:0]        variant_tag;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               status;
    logic [3:0]         box_index;
    logic [15:0]        hit_name;
    logic [15:0]        hit_variant;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [1:0]         face;
    logic [16:0]        distance;
    logic               last;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_BOX,
    ST_FACE,
    ST_DIV,
    ST_OFF,
    ST_CHK,
    ST_SCAN_RD,
    ST_SCAN,
    ST_PICK_RD,
    ST_PICK_TAG,
    ST_SORT_OUT,
    ST_PQ_TAG,
    ST_PQ_OUT,
    ST_NEXT,
    ST_SINGLE,
    ST_WAIT
  } state_t;

endpackage

### rtl/core/aabb_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No package dependency.
module aabb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/aabb_div.sv
// Restoring divider, one quotient bit per cycle: q = (num << 16) / den, num <= den.
// Depends on aabb_pkg.
module aabb_div #(
  parameter int NB = 17
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NB-1:0]          num,
  input  logic [NB-1:0]          den,
  output logic                   done,
  output logic [aabb_pkg::T_BITS-1:0] quo
);
  import aabb_pkg::*;

  logic [NB:0]          rem;
  logic [NB-1:0]        dv;
  logic [4:0]           cnt;
  logic                 busy;
  logic [NB+1:0]        trial;

  assign trial = {rem, 1'b0} - {2'b00, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        dv   <= den;
        if (num >= den) begin
          rem <= {1'b0, num - den};
          quo <= T_BITS'(1);
        end else begin
          rem <= {1'b0, num};
          quo <= '0;
        end
      end else if (busy) begin
        if (!trial[NB+1]) begin
          rem <= trial[NB:0];
          quo <= {quo[T_BITS-2:0], 1'b1};
        end else begin
          rem <= {rem[NB-1:0], 1'b0};
          quo <= {quo[T_BITS-2:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/core/aabb_table_collision_query.sv
// Top level of the box table collision query block.
// Depends on aabb_pkg, aabb_ram and aabb_div.
//
// Usage: one request channel (req_valid/req_stall/req) carries a command:
// clear, append a box, point query, rectangle query or segment query. The
// result channel (rsp_valid/rsp_stall/rsp) returns one or more results per
// request; the final one has last set. A request with no hits, a clear and
// an append return a single result (status=1 on an append to a full table).
// Requests are handled one at a time; req_stall is high while one is open.
// Point and rectangle queries visit each stored box in turn. A segment query
// runs a division for each box face that the segment can reach (one serial
// quotient bit per cycle), then a selection sort over the hit memory that
// rescans all stored hits for each reported hit. Box coordinates, tags and
// hits live in synchronous memories read one entry a cycle. Reset empties
// the table (count zero); the memories are not cleared. A stalled result
// holds until taken; the block waits on it before moving on.
module aabb_table_collision_query #(
  parameter int BOXES      = aabb_pkg::BOXES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  aabb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output aabb_pkg::rsp_t rsp
);
  import aabb_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int DW = CW + 1;
  localparam int HW = IDX_BITS + 2 * CW + 2 + T_BITS;

  state_t state, state_next;

  logic [IDX_BITS:0]    box_count;
  req_t                 cur;
  logic                 app_full;
  logic [IDX_BITS:0]    bi;
  logic [1:0]           fsel;
  logic [HIT_AW:0]      hit_n;
  logic [HIT_AW:0]      k, j;
  logic                 found;
  logic [HIT_AW-1:0]    best;
  logic [T_BITS-1:0]    best_t;
  logic [HIT_AW-1:0]    last_j;
  logic [T_BITS-1:0]    last_t;
  logic                 any;

  logic signed [CW-1:0] bxmin, bymin, bxmax, bymax;
  logic signed [DW-1:0] f_r, s_off_r, d_off_r, s_on_r, d_on_r;
  logic [T_BITS-1:0]    t_r;
  logic signed [CW+T_BITS+1:0] prod_r;
  logic signed [DW:0]   off_r;

  logic                 c_we, t_we, h_we;
  logic [IDX_BITS-1:0]  c_wa, c_ra;
  logic [63:0]          c_wd, c_rd;
  logic [31:0]          t_wd, t_rd;
  logic [HIT_AW-1:0]    h_wa, h_ra;
  logic [HW-1:0]        h_wd, h_rd;

  logic                 d_start, d_done;
  logic [DW-1:0]        d_num, d_den;
  logic [T_BITS-1:0]    d_q;

  rsp_t                 out_next;
  logic                 out_load;

  logic                 pend, pend_next;
  rsp_t                 pend_rsp;
  logic                 rsp_valid_next;
  rsp_t                 rsp_next;
  logic                 rsp_load;

  aabb_ram #(.WIDTH(64), .DEPTH(16)) u_coords (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  aabb_ram #(.WIDTH(32), .DEPTH(16)) u_tags (
    .clk, .we(t_we), .waddr(c_wa), .wdata(t_wd), .raddr(c_ra), .rdata(t_rd));
  aabb_ram #(.WIDTH(HW), .DEPTH(MAX_HITS)) u_hits (
    .clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  aabb_div #(.NB(DW)) u_div (
    .clk, .rst, .start(d_start), .num(d_num), .den(d_den), .done(d_done), .quo(d_q));

  logic [IDX_BITS:0] cnt_lim;
  assign cnt_lim = (box_count > (IDX_BITS+1)'(BOXES)) ? (IDX_BITS+1)'(BOXES) : box_count;

  assign {bxmin, bymin, bxmax, bymax} = c_rd;

  // face selection: 0 xmax, 1 xmin, 2 ymax, 3 ymin
  logic signed [DW-1:0] ax, ay, dx, dy, f_sel;
  logic                 xface;
  logic [1:0]           fcode;
  assign ax = DW'(cur.coord_a_x);
  assign ay = DW'(cur.coord_a_y);
  assign dx = DW'(cur.coord_b_x) - DW'(cur.coord_a_x);
  assign dy = DW'(cur.coord_b_y) - DW'(cur.coord_a_y);
  assign xface = !fsel[1];
  always_comb begin
    case (fsel)
      2'd0:    begin f_sel = DW'(bxmax); fcode = FACE_XMAX; end
      2'd1:    begin f_sel = DW'(bxmin); fcode = FACE_XMIN; end
      2'd2:    begin f_sel = DW'(bymax); fcode = FACE_YMAX; end
      default: begin f_sel = DW'(bymin); fcode = FACE_YMIN; end
    endcase
  end

  logic signed [DW:0] num_w;
  logic [DW-1:0]      an, ad;
  logic               face_ok;
  assign num_w = {f_r[DW-1], f_r} - {s_on_r[DW-1], s_on_r};
  always_comb begin
    an = num_w[DW] ? DW'(-num_w) : DW'(num_w);
    ad = d_on_r[DW-1] ? DW'(-d_on_r) : DW'(d_on_r);
    face_ok = (d_on_r != '0) && !(num_w != '0 && (num_w[DW] != d_on_r[DW-1])) && (an <= ad);
  end
  assign d_num = an;
  assign d_den = ad;

  logic signed [DW:0] onf;
  logic               inside_ok;
  assign onf = {f_r[DW-1], f_r};
  always_comb begin
    if (xface) begin
      inside_ok = onf >= (DW+1)'(bxmin) && onf <= (DW+1)'(bxmax) &&
                  off_r >= (DW+1)'(bymin) && off_r <= (DW+1)'(bymax);
    end else begin
      inside_ok = off_r >= (DW+1)'(bxmin) && off_r <= (DW+1)'(bxmax) &&
                  onf >= (DW+1)'(bymin) && onf <= (DW+1)'(bymax);
    end
  end

  logic [IDX_BITS-1:0]  h_idx;
  logic signed [CW-1:0] h_px, h_py;
  logic [1:0]           h_face;
  logic [T_BITS-1:0]    h_t;
  assign {h_idx, h_px, h_py, h_face, h_t} = h_rd;

  assign h_wd = {bi[IDX_BITS-1:0], xface ? CW'(f_r) : CW'(off_r),
                 xface ? CW'(off_r) : CW'(f_r), fcode, t_r};

  logic scan_ok;
  assign scan_ok = (k == '0) || (h_t < last_t) ||
                   (h_t == last_t && j[HIT_AW-1:0] < last_j);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_valid) begin
        case (req.cmd)
          CMD_POINT, CMD_RECT, CMD_SEG: state_next = ST_RD;
          default: state_next = ST_SINGLE;
        endcase
      end
      ST_RD: state_next = (bi < cnt_lim) ? ST_BOX : ST_NEXT;
      ST_BOX: begin
        if (cur.cmd == CMD_SEG) state_next = ST_FACE;
        else state_next = ST_PQ_TAG;
      end
      ST_PQ_TAG: state_next = ST_PQ_OUT;
      ST_PQ_OUT: if (!rsp_valid || !rsp_stall) state_next = ST_RD;
      ST_FACE: state_next = face_ok ? ST_DIV : ST_CHK;
      ST_DIV: if (d_done) state_next = ST_OFF;
      ST_OFF: state_next = ST_CHK;
      ST_CHK: state_next = ST_RD;
      ST_NEXT: begin
        if (cur.cmd == CMD_SEG && hit_n != '0) state_next = ST_SCAN_RD;
        else if (!any) state_next = ST_SINGLE;
        else state_next = ST_WAIT;
      end
      ST_SCAN_RD: state_next = ST_SCAN;
      ST_SCAN: state_next = (j + 1'b1 == hit_n) ? ST_PICK_RD : ST_SCAN_RD;
      ST_PICK_RD: state_next = ST_PICK_TAG;
      ST_PICK_TAG: state_next = ST_SORT_OUT;
      ST_SORT_OUT: if (!rsp_valid || !rsp_stall) begin
        state_next = (k + 1'b1 == hit_n) ? ST_WAIT : ST_SCAN_RD;
      end
      ST_SINGLE: if (!rsp_valid || !rsp_stall) state_next = ST_WAIT;
      ST_WAIT: if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  logic seg_hit_w;
  assign seg_hit_w = (state == ST_CHK) && face_ok && inside_ok && (hit_n < (HIT_AW+1)'(MAX_HITS));
  always_comb begin
    req_stall = (state != ST_IDLE);
    c_we = 1'b0;
    t_we = 1'b0;
    c_wa = box_count[IDX_BITS-1:0];
    c_wd = {req.coord_a_x, req.coord_a_y, req.coord_b_x, req.coord_b_y};
    t_wd = {req.variant_tag, req.name_tag};
    c_ra = bi[IDX_BITS-1:0];
    h_we = seg_hit_w;
    h_wa = hit_n[HIT_AW-1:0];
    h_ra = j[HIT_AW-1:0];
    d_start = (state == ST_FACE) && face_ok;
    out_load = 1'b0;
    out_next = '0;
    if (state == ST_IDLE && req_valid && req.cmd == CMD_APPEND &&
        box_count < (IDX_BITS+1)'(BOXES)) begin
      c_we = 1'b1;
      t_we = 1'b1;
    end
    if (state == ST_PICK_RD || state == ST_PICK_TAG || state == ST_SORT_OUT) h_ra = best;
    if (state == ST_PICK_TAG || state == ST_SORT_OUT) c_ra = h_idx;
    case (state)
      ST_PQ_OUT: if (!rsp_valid || !rsp_stall) begin
        out_load = cur.cmd == CMD_POINT ?
          (cur.coord_a_x >= bxmin && cur.coord_a_x <= bxmax &&
           cur.coord_a_y >= bymin && cur.coord_a_y <= bymax) :
          (bxmin <= cur.coord_b_x && bxmax >= cur.coord_a_x &&
           bymin <= cur.coord_b_y && bymax >= cur.coord_a_y);
        out_next.hit = 1'b1;
        out_next.box_index = bi[IDX_BITS-1:0];
        out_next.hit_name = t_rd[15:0];
        out_next.hit_variant = t_rd[31:16];
        if (cur.cmd == CMD_POINT) begin
          out_next.pos_x = cur.coord_a_x;
          out_next.pos_y = cur.coord_a_y;
        end
      end
      ST_SORT_OUT: if (!rsp_valid || !rsp_stall) begin
        out_load = 1'b1;
        out_next.hit = 1'b1;
        out_next.box_index = h_idx;
        out_next.hit_name = t_rd[15:0];
        out_next.hit_variant = t_rd[31:16];
        out_next.pos_x = h_px;
        out_next.pos_y = h_py;
        out_next.face = h_face;
        out_next.distance = h_t;
      end
      ST_SINGLE: if (!rsp_valid || !rsp_stall) begin
        out_load = 1'b1;
        out_next.last = 1'b1;
        out_next.status = (cur.cmd == CMD_APPEND) && app_full;
      end
      default: ;
    endcase
  end

  // hold one result back so the final one can be marked last
  always_comb begin
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_load = 1'b0;
    rsp_next = pend_rsp;
    pend_next = pend;
    if (out_load) begin
      if (state == ST_SINGLE) begin
        rsp_load = 1'b1;
        rsp_next = out_next;
      end else begin
        rsp_load = pend;
        pend_next = 1'b1;
      end
    end else if (state == ST_WAIT && pend && (!rsp_valid || !rsp_stall)) begin
      rsp_load = 1'b1;
      rsp_next.last = 1'b1;
      pend_next = 1'b0;
    end
    if (rsp_load) rsp_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      box_count <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      pend      <= pend_next;
      if (rsp_load) rsp <= rsp_next;
      if (out_load && state != ST_SINGLE) pend_rsp <= out_next;
      if (state == ST_IDLE && req_valid) begin
        if (req.cmd == CMD_CLEAR) box_count <= '0;
        else if (req.cmd == CMD_APPEND && box_count < (IDX_BITS+1)'(BOXES))
          box_count <= box_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any <= 1'b0;
    end else begin
      if (state == ST_IDLE) any <= 1'b0;
      if (out_load) any <= 1'b1;
    end
    case (state)
      ST_IDLE: if (req_valid) begin
        cur      <= req;
        app_full <= box_count >= (IDX_BITS+1)'(BOXES);
        bi       <= '0;
        fsel     <= 2'd0;
        hit_n    <= '0;
        k        <= '0;
      end
      ST_RD: ;
      ST_BOX: if (cur.cmd == CMD_SEG) begin
        f_r     <= f_sel;
        s_on_r  <= xface ? ax : ay;
        d_on_r  <= xface ? dx : dy;
        s_off_r <= xface ? ay : ax;
        d_off_r <= xface ? dy : dx;
      end
      ST_PQ_OUT: if (!rsp_valid || !rsp_stall) bi <= bi + 1'b1;
      ST_DIV: if (d_done) begin
        t_r    <= d_q;
        prod_r <= $signed({1'b0, d_q}) * d_off_r;
      end
      ST_OFF: off_r <= {s_off_r[DW-1], s_off_r} + (DW+1)'(prod_r >>> FRAC_BITS);
      ST_CHK: begin
        if (seg_hit_w) hit_n <= hit_n + 1'b1;
        fsel <= fsel + 2'd1;
        if (fsel == 2'd3) bi <= bi + 1'b1;
      end
      ST_NEXT: begin
        j <= '0;
        found <= 1'b0;
      end
      ST_SCAN: begin
        if (scan_ok && (!found || h_t >= best_t)) begin
          best   <= j[HIT_AW-1:0];
          best_t <= h_t;
          found  <= 1'b1;
        end
        j <= j + 1'b1;
      end
      ST_SORT_OUT: if (!rsp_valid || !rsp_stall) begin
        last_j <= best;
        last_t <= best_t;
        k <= k + 1'b1;
        j <= '0;
        found <= 1'b0;
      end
      default: ;
    endcase
  end

  // a face's box read must stay valid: ST_CHK falls back to ST_RD which re-reads bi
  // (bi advances only after the fourth face)

  assert property (@(posedge clk) disable iff (rst) box_count <= (IDX_BITS+1)'(BOXES))
    else $error("box count beyond table size");
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> req_stall)
    else $error("request taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    hit_n <= (HIT_AW+1)'(MAX_HITS))
    else $error("hit count overflow");
endmodule

### tb/aabb_table_collision_query_checker.sv
`timescale 1ns / 100ps
// Checker for the box table collision query block: keeps its own box table,
// predicts the results of each accepted request and compares them in order.
// Depends on aabb_pkg for the request and result structs and command codes.
module aabb_table_collision_query_checker
  import aabb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending,
  output int   req_seen,
  output int   rsp_seen,
  output int   hits_seen,
  output int   accepts
);

  rsp_t expected_results[$];

  longint box_xmin[16], box_ymin[16], box_xmax[16], box_ymax[16];
  logic [31:0] box_tag[16];
  int unsigned box_total;

  int unsigned seg_idx[64], seg_face[64];
  longint seg_px[64], seg_py[64], seg_t[64];
  int unsigned seg_n;

  function automatic bit in_box(int unsigned i, longint x, longint y);
    return x >= box_xmin[i] && x <= box_xmax[i] && y >= box_ymin[i] && y <= box_ymax[i];
  endfunction

  function automatic rsp_t make_result(bit hit, int unsigned i, longint px, longint py,
                                       int unsigned face, longint t);
    rsp_t r;
    r = '0;
    r.hit = hit;
    r.box_index = i[3:0];
    r.hit_name = box_tag[i][15:0];
    r.hit_variant = box_tag[i][31:16];
    r.pos_x = px[15:0];
    r.pos_y = py[15:0];
    r.face = face[1:0];
    r.distance = t[16:0];
    return r;
  endfunction

  function automatic void face_hit(int unsigned i, longint f, longint s_on, longint d_on,
                                   longint s_off, longint d_off, bit xface,
                                   int unsigned face);
    longint num, an, ad, t, off;
    num = f - s_on;
    if (d_on == 0) return;
    if (num != 0 && ((num < 0) != (d_on < 0))) return;
    an = num < 0 ? -num : num;
    ad = d_on < 0 ? -d_on : d_on;
    if (an > ad) return;
    t = (an <<< 16) / ad;
    off = s_off + ((t * d_off) >>> 16);
    if (xface ? !in_box(i, f, off) : !in_box(i, off, f)) return;
    if (seg_n >= 64) return;
    seg_idx[seg_n] = i;
    seg_px[seg_n] = xface ? f : off;
    seg_py[seg_n] = xface ? off : f;
    seg_face[seg_n] = face;
    seg_t[seg_n] = t;
    seg_n++;
  endfunction

  function automatic void predict_collisions(req_t r);
    longint ax, ay, bx, by;
    rsp_t res[$];
    rsp_t single;
    bit taken[64];
    int unsigned best;
    bit found;
    ax = longint'(r.coord_a_x);
    ay = longint'(r.coord_a_y);
    bx = longint'(r.coord_b_x);
    by = longint'(r.coord_b_y);
    single = '0;
    single.last = 1'b1;
    case (r.cmd)
      CMD_CLEAR: box_total = 0;
      CMD_APPEND: begin
        if (box_total >= 16) begin
          single.status = 1'b1;
        end else begin
          box_xmin[box_total] = ax;
          box_ymin[box_total] = ay;
          box_xmax[box_total] = bx;
          box_ymax[box_total] = by;
          box_tag[box_total] = {r.variant_tag, r.name_tag};
          box_total++;
        end
      end
      CMD_POINT: begin
        for (int unsigned i = 0; i < box_total; i++)
          if (in_box(i, ax, ay)) res = {res, make_result(1, i, ax, ay, 0, 0)};
      end
      CMD_RECT: begin
        for (int unsigned i = 0; i < box_total; i++)
          if (box_xmin[i] <= bx && box_xmax[i] >= ax && box_ymin[i] <= by &&
              box_ymax[i] >= ay)
            res = {res, make_result(1, i, 0, 0, 0, 0)};
      end
      CMD_SEG: begin
        seg_n = 0;
        for (int unsigned i = 0; i < box_total; i++) begin
          face_hit(i, box_xmax[i], ax, bx - ax, ay, by - ay, 1, FACE_XMAX);
          face_hit(i, box_xmin[i], ax, bx - ax, ay, by - ay, 1, FACE_XMIN);
          face_hit(i, box_ymax[i], ay, by - ay, ax, bx - ax, 0, FACE_YMAX);
          face_hit(i, box_ymin[i], ay, by - ay, ax, bx - ax, 0, FACE_YMIN);
        end
        taken = '{default: 1'b0};
        for (int unsigned k = 0; k < seg_n; k++) begin
          best = 0;
          found = 0;
          for (int unsigned j = 0; j < seg_n; j++)
            if (!taken[j] && (!found || seg_t[j] >= seg_t[best])) begin
              best = j;
              found = 1;
            end
          taken[best] = 1;
          res = {res, make_result(1, seg_idx[best], seg_px[best], seg_py[best],
                                  seg_face[best], seg_t[best])};
        end
      end
      default: ;
    endcase
    if (res.size() == 0) res = {res, single};
    res[res.size() - 1].last = 1'b1;
    expected_results = {expected_results, res};
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      box_total = 0;
      errors <= 0;
      req_seen <= 0;
      rsp_seen <= 0;
      hits_seen <= 0;
      accepts <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_collisions(req);
        req_seen <= req_seen + 1;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_seen <= rsp_seen + 1;
        if (rsp.hit) hits_seen <= hits_seen + 1;
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("%0t: unexpected result %p", $time, rsp);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (rsp.hit !== want.hit || rsp.status !== want.status ||
              rsp.box_index !== want.box_index || rsp.hit_name !== want.hit_name ||
              rsp.hit_variant !== want.hit_variant || rsp.pos_x !== want.pos_x ||
              rsp.pos_y !== want.pos_y || rsp.face !== want.face ||
              rsp.distance !== want.distance || rsp.last !== want.last) begin
            if (errors < 10) $display("%0t: result mismatch\n  exp %p\n  got %p",
                                      $time, want, rsp);
            errors <= errors + 1;
          end
        end
      end
      accepts <= accepts + ((req_valid && !req_stall) || (rsp_valid && !rsp_stall));
    end
    pending <= expected_results.size();
  end

endmodule

### tb/aabb_table_collision_query_tb.sv
`timescale 1ns / 100ps
// Testbench top for the box table collision query block: drives requests,
// random stalls and the verdict. Depends on aabb_pkg, the block and its checker.
module aabb_table_collision_query_tb;
  import aabb_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  rsp_t rsp;

  int errors, pending, req_seen, rsp_seen, hits_seen, accepts;
  bit idling = 1;
  int hold_requests = 0;
  int sent = 0;

  always #5 clk = ~clk;

  aabb_table_collision_query dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  aabb_table_collision_query_checker checker_i (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp), .errors(errors),
    .pending(pending), .req_seen(req_seen), .rsp_seen(rsp_seen),
    .hits_seen(hits_seen), .accepts(accepts)
  );

  // receiver: random stall bursts, plus long holds on request
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done < hold_requests) begin
        holds_done++;
        rsp_stall <= 1;
        repeat (400) @(posedge clk);
        rsp_stall <= 0;
      end else if (idling && !rst && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        rsp_stall <= 0;
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle_cycles, seen;
    idle_cycles = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (accepts != seen || rst) begin
        seen = accepts;
        idle_cycles = 0;
      end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("aabb_table_collision_query regression: fail");
        $finish;
      end
    end
  end

  task automatic send(logic [2:0] cmd, logic signed [15:0] ax, logic signed [15:0] ay,
                      logic signed [15:0] bx, logic signed [15:0] by,
                      logic [15:0] name_tag = 16'h0, logic [15:0] variant_tag = 16'h0);
    req_valid <= 1;
    req.cmd <= cmd;
    req.coord_a_x <= ax;
    req.coord_a_y <= ay;
    req.coord_b_x <= bx;
    req.coord_b_y <= by;
    req.name_tag <= name_tag;
    req.variant_tag <= variant_tag;
    do @(posedge clk); while (req_stall);
    sent++;
    if (idling && $urandom_range(0, 3) == 0) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] near_coord();
    if ($urandom_range(0, 9) == 0) return $signed(16'($urandom_range(0, 65535)));
    return $signed(16'($urandom_range(0, 127))) - 16'sd64;
  endfunction

  task automatic append_random();
    logic signed [15:0] x0, y0, x1, y1;
    x0 = near_coord();
    y0 = near_coord();
    if ($urandom_range(0, 9) == 0) begin
      x1 = near_coord();
      y1 = near_coord();
    end else begin
      x1 = x0 + $signed(16'($urandom_range(0, 40)));
      y1 = y0 + $signed(16'($urandom_range(0, 40)));
      if (x1 < x0) x1 = 16'sh7fff;
      if (y1 < y0) y1 = 16'sh7fff;
    end
    send(CMD_APPEND, x0, y0, x1, y1, 16'($urandom_range(0, 65535)),
         16'($urandom_range(0, 65535)));
  endtask

  task automatic wait_drained();
    req_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    bit drained_once;
    drained_once = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(CMD_POINT, 0, 0, 0, 0);
    send(CMD_APPEND, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'hffff, 16'h0000);
    send(CMD_APPEND, -10, -10, 10, 10, 16'h0000, 16'hffff);
    send(CMD_APPEND, 20, 20, 5, 5, 16'h1234, 16'habcd);
    send(CMD_APPEND, 3, 3, 3, 3, 16'h5a5a, 16'ha5a5);
    send(CMD_POINT, -16'sd32768, 16'sd32767, 0, 0);
    send(CMD_POINT, 3, 3, 0, 0);
    send(CMD_POINT, 10, -10, 0, 0);
    send(CMD_RECT, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send(CMD_RECT, 11, 11, 12, 12);
    send(CMD_RECT, 10, 10, -10, -10);
    send(CMD_SEG, -20, -7, 30, 13);
    send(CMD_SEG, 0, -30, 0, 30);
    send(CMD_SEG, 5, 5, 5, 5);
    send(CMD_SEG, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send(CMD_SEG, 3, -20, 3, 3);
    send(3'd5, 1, 1, 1, 1);
    send(3'd7, -1, -1, -1, -1, 16'hffff, 16'hffff);
    send(CMD_CLEAR, 0, 0, 0, 0);
    send(CMD_SEG, -5, -5, 5, 5);

    while (sent < 380) begin
      if (sent >= 120 && hold_requests == 0) hold_requests = 1;
      if (sent >= 220 && !drained_once) begin
        drained_once = 1;
        wait_drained();
      end
      if (sent >= 320) idling = 0;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send(CMD_CLEAR, 0, 0, 0, 0);
        repeat (17) append_random();
      end else if (pick < 12) send(CMD_CLEAR, 0, 0, 0, 0);
      else if (pick < 40) append_random();
      else if (pick < 56) send(CMD_POINT, near_coord(), near_coord(), near_coord(),
                               near_coord());
      else if (pick < 70) send(CMD_RECT, near_coord(), near_coord(), near_coord(),
                              near_coord());
      else if (pick < 94) begin
        if ($urandom_range(0, 4) == 0)
          send(CMD_SEG, near_coord(), 8, near_coord(), 8);
        else
          send(CMD_SEG, near_coord(), near_coord(), near_coord(), near_coord());
      end else
        send(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)));
    end
    wait_drained();
    repeat (200) @(posedge clk);

    $display("covered %0d requests (all commands, full table, stalls), %0d results, %0d hits",
             req_seen, rsp_seen, hits_seen);
    if (errors == 0 && pending == 0) begin
      $display("aabb_table_collision_query regression: pass");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending);
      $display("aabb_table_collision_query regression: fail");
    end
    $finish;
  end

endmodule
